### src/smx_pkg.sv
// shared types, codes and defaults of the stack machine executor
package smx_pkg;

	// default sizes
	localparam int STACK_DEPTH_DEF = 256;
	localparam int DATA_WIDTH_DEF  = 32;

	// fixed field widths of the channels
	localparam int CMD_W = 3;
	localparam int STS_W = 3;
	localparam int IO_W  = 32;

	// instruction codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 3'd0,
		CMD_OUT  = 3'd1,
		CMD_ADD  = 3'd2,
		CMD_SUB  = 3'd3,
		CMD_MUL  = 3'd4,
		CMD_DIV  = 3'd5,
		CMD_HLT  = 3'd6,
		CMD_UNK  = 3'd7
	} cmd_t;

	// result status codes
	typedef enum logic [STS_W-1:0] {
		STS_OK      = 3'd0,
		STS_UNDER   = 3'd1,
		STS_OVER    = 3'd2,
		STS_DIVZ    = 3'd3,
		STS_UNKNOWN = 3'd4,
		STS_HALTED  = 3'd5
	} status_t;

	// request from the sequencer to the multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} alu_req_t;

endpackage

### src/smx_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/smx_alu.sv
// iterative multiply and truncating signed divide, one bit per cycle
module smx_alu #(
	parameter int DATA_WIDTH = smx_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smx_pkg::alu_req_t     req,
	input  logic [DATA_WIDTH-1:0] lhs,
	input  logic [DATA_WIDTH-1:0] rhs,
	output logic                  busy,
	output logic [DATA_WIDTH-1:0] result
);
	import smx_pkg::*;

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic                  busy_q;
	logic [CW-1:0]         cnt_q;
	logic                  div_q;
	logic                  neg_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] sh_q;
	logic [DATA_WIDTH-1:0] op_q;

	logic [DATA_WIDTH-1:0] lhs_abs;
	logic [DATA_WIDTH-1:0] rhs_abs;
	logic [DATA_WIDTH:0]   rem_sh;
	logic                  rem_ge;
	logic [DATA_WIDTH:0]   rem_sub;

	// operand magnitudes for the divider
	assign lhs_abs = lhs[DATA_WIDTH-1] ? (~lhs + 1'b1) : lhs;
	assign rhs_abs = rhs[DATA_WIDTH-1] ? (~rhs + 1'b1) : rhs;

	// restoring divide step
	assign rem_sh  = {acc_q, sh_q[DATA_WIDTH-1]};
	assign rem_ge  = rem_sh >= {1'b0, op_q};
	assign rem_sub = rem_sh - {1'b0, op_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DATA_WIDTH);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CW'(1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
			acc_q <= '0;
			if (req.is_div) begin
				sh_q <= lhs_abs;
				op_q <= rhs_abs;
			end else begin
				sh_q <= rhs;
				op_q <= lhs;
			end
		end else if (busy_q) begin
			if (div_q) begin
				if (rem_ge) begin
					acc_q <= rem_sub[DATA_WIDTH-1:0];
				end else begin
					acc_q <= rem_sh[DATA_WIDTH-1:0];
				end
				sh_q <= {sh_q[DATA_WIDTH-2:0], rem_ge};
			end else begin
				if (sh_q[0]) begin
					acc_q <= acc_q + op_q;
				end
				sh_q <= sh_q >> 1;
				op_q <= op_q << 1;
			end
		end
	end

	assign busy   = busy_q;
	assign result = div_q ? (neg_q ? (~sh_q + 1'b1) : sh_q) : acc_q;

endmodule

### src/stack_machine_executor_top.sv
// stack machine executor: sequencer, top-of-stack register and stack ram
//
// Input channel (in_valid/in_ready) carries one decoded instruction per beat:
// command and a signed 32-bit operand used by push. Output channel
// (out_valid/out_ready) returns exactly one result beat per instruction:
// status, has_value, out_value and halted.
// The top of stack lives in a register; all deeper words live in the stack
// ram, which has a registered read. An instruction is taken in the idle
// state, which also issues the ram read of the second word, and executed in
// the exec state, which waits while the output register still holds an
// untaken beat; push, out, add, sub, hlt and all errors then finish there.
// mul and div without an error go on to the bit-serial multiply/divide unit
// in the alu state and finish once it is done and the output register is free.
// The result sits in an output register; when the receiver stalls the
// finishing instruction waits for that register and no new beat is taken.
// Reset empties the stack and clears the stopped state; ram contents are not
// cleared and no clearing pass is needed. Once hlt or an error stops the
// machine, every further beat returns status halted until reset.
module stack_machine_executor_top #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
	parameter int DATA_WIDTH  = smx_pkg::DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [smx_pkg::CMD_W-1:0] command,
	input  logic signed [smx_pkg::IO_W-1:0] operand,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [smx_pkg::STS_W-1:0] status,
	output logic                      has_value,
	output logic signed [smx_pkg::IO_W-1:0] out_value,
	output logic                      halted
);
	import smx_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_ALU  = 3'b100
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] opnd_q;
	logic [DW-1:0]         depth_q;
	logic                  stopped_q;
	logic [DATA_WIDTH-1:0] top_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic                  has_value_q;
	logic [IO_W-1:0]       out_value_q;
	logic                  halted_q;

	logic                  in_beat;
	logic                  out_free;
	logic [DATA_WIDTH-1:0] second;
	alu_req_t              alu_req;
	logic                  alu_busy;
	logic [DATA_WIDTH-1:0] alu_result;

	// execute-stage decisions
	status_t               ex_sts;
	logic                  ex_has;
	logic [DATA_WIDTH-1:0] ex_val;
	logic [DW-1:0]         ex_depth;
	logic [DATA_WIDTH-1:0] ex_top;
	logic                  ex_wr;
	logic                  ex_go_alu;
	logic                  ex_stop;
	logic                  fin_exec;
	logic                  fin_alu;

	assign in_ready = state_q == S_IDLE;
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// stack ram holds every word below the top of stack
	smx_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (fin_exec && ex_wr),
		.waddr(AW'(depth_q - DW'(1))),
		.wdata(top_q),
		.re   (in_beat),
		.raddr(AW'(depth_q - DW'(2))),
		.rdata(second)
	);

	// bit-serial multiply/divide
	smx_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.lhs   (second),
		.rhs   (top_q),
		.busy  (alu_busy),
		.result(alu_result)
	);

	// decode and check the held instruction against the stack
	always_comb begin
		ex_sts    = STS_OK;
		ex_has    = 1'b0;
		ex_val    = '0;
		ex_depth  = depth_q;
		ex_top    = top_q;
		ex_wr     = 1'b0;
		ex_go_alu = 1'b0;
		if (stopped_q) begin
			ex_sts = STS_HALTED;
		end else begin
			case (cmd_q)
				CMD_PUSH: begin
					if (depth_q == DW'(STACK_DEPTH)) begin
						ex_sts = STS_OVER;
					end else begin
						ex_wr    = depth_q != '0;
						ex_top   = opnd_q;
						ex_depth = depth_q + 1'b1;
					end
				end
				CMD_OUT: begin
					if (depth_q == '0) begin
						ex_sts = STS_UNDER;
					end else begin
						ex_has   = 1'b1;
						ex_val   = top_q;
						ex_top   = second;
						ex_depth = depth_q - 1'b1;
					end
				end
				CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
					if (depth_q < DW'(2)) begin
						ex_sts = STS_UNDER;
					end else if (cmd_q == CMD_DIV && top_q == '0) begin
						ex_sts = STS_DIVZ;
					end else if (cmd_q inside {CMD_MUL, CMD_DIV}) begin
						ex_go_alu = 1'b1;
					end else begin
						ex_top   = (cmd_q == CMD_ADD) ? (second + top_q) : (second - top_q);
						ex_depth = depth_q - 1'b1;
					end
				end
				CMD_HLT: begin
					ex_sts = STS_OK;
				end
				default: begin
					ex_sts = STS_UNKNOWN;
				end
			endcase
		end
		ex_stop = stopped_q || (cmd_q == CMD_HLT) || (ex_sts != STS_OK);
	end

	assign fin_exec       = (state_q == S_EXEC) && !ex_go_alu && out_free;
	assign fin_alu        = (state_q == S_ALU) && !alu_busy && out_free;
	assign alu_req.start  = (state_q == S_EXEC) && ex_go_alu;
	assign alu_req.is_div = cmd_q == CMD_DIV;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ex_go_alu) begin
						state_q <= S_ALU;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_ALU: begin
					if (fin_alu) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// instruction capture
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q  <= cmd_t'(command);
			opnd_q <= DATA_WIDTH'(operand);
		end
	end

	// stack depth and stopped state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			stopped_q <= 1'b0;
		end else if (fin_exec) begin
			depth_q   <= ex_depth;
			stopped_q <= ex_stop;
		end else if (fin_alu) begin
			depth_q   <= depth_q - 1'b1;
		end
	end

	// top of stack register
	always_ff @(posedge clk) begin
		if (fin_exec) begin
			top_q <= ex_top;
		end else if (fin_alu) begin
			top_q <= alu_result;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_exec || fin_alu) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fin_exec) begin
			status_q    <= ex_sts;
			has_value_q <= ex_has;
			out_value_q <= IO_W'(signed'(ex_val));
			halted_q    <= ex_stop;
		end else if (fin_alu) begin
			status_q    <= STS_OK;
			has_value_q <= 1'b0;
			out_value_q <= '0;
			halted_q    <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign has_value = has_value_q;
	assign out_value = out_value_q;
	assign halted    = halted_q;

`ifndef SYNTHESIS
	// the stack never holds more words than it has room for
	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// a stopped machine stays stopped until reset
	assert property (@(posedge clk) disable iff (!arst_n) stopped_q |=> stopped_q)
		else $error("stopped state cleared without reset");

	// the multiply/divide unit only starts with two words on the stack
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> (depth_q >= DW'(2) && !stopped_q))
		else $error("arithmetic unit started without two operands");

	// a delivered value always comes with status ok
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_exec && ex_has |=> (out_valid && has_value && status == STS_OK))
		else $error("value delivered with a bad status");
`endif

endmodule
